@@ hw/rtl/nmea_gga_field_parser_assert.svh @@
// Assertion macros shared by the GGA parser checkers.
// Each macro expects signals clk and rst_n in the enclosing scope.
`ifndef NMEA_GGA_FIELD_PARSER_ASSERT_SVH
`define NMEA_GGA_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define NGFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define NGFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ngfp_pkg.sv @@
// Shared types and constants for the NMEA GGA field parser.
// No dependencies; used by the parser top level and its checker.
`timescale 1ns / 1ps

package ngfp_pkg;

    // Stream and register widths
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 26;
    localparam int ALT_W       = 32;
    localparam int MAG_W       = 31;
    localparam int FIELD_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int M_TDATA_W   = 72;
    localparam int WEIGHT_W    = 22;

    // Register indexes of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_FIELD = 2'd0,
        REG_FIX_FIELD  = 2'd1,
        REG_ALT_FIELD  = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

    // Reset values of the field index registers
    localparam logic [FIELD_W-1:0] TIME_FIELD_RST = 4'd2;
    localparam logic [FIELD_W-1:0] FIX_FIELD_RST  = 4'd7;
    localparam logic [FIELD_W-1:0] ALT_FIELD_RST  = 4'd10;
    localparam logic [FIELD_W-1:0] FIELD_MAX      = 4'd15;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_F   = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_F   = 8'h66;

    // Altitude reported when there is no fix
    localparam logic [ALT_W-1:0] NO_FIX_ALT = 32'hFFFF_FC18;
    localparam logic [MAG_W-1:0] MAG_MAX    = 31'h7FFF_FFFF;

    // Weight of each timestamp digit in centiseconds (HH MM SS ss)
    function automatic logic [WEIGHT_W-1:0] time_weight(input logic [2:0] pos);
        logic [WEIGHT_W-1:0] w;
        begin
            unique case (pos)
                3'd0:    w = 22'd3600000;
                3'd1:    w = 22'd360000;
                3'd2:    w = 22'd60000;
                3'd3:    w = 22'd6000;
                3'd4:    w = 22'd1000;
                3'd5:    w = 22'd100;
                3'd6:    w = 22'd10;
                default: w = 22'd1;
            endcase
            return w;
        end
    endfunction

    // Decode a checksum character; non-hex characters wrap as (c - '0') mod 16
    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] diff;
        begin
            if (c >= CH_UP_A && c <= CH_UP_F)
                diff = c - CH_UP_A + 8'd10;
            else if (c >= CH_LO_A && c <= CH_LO_F)
                diff = c - CH_LO_A + 8'd10;
            else
                diff = c - CH_ZERO;
            return diff[3:0];
        end
    endfunction

endpackage

@@ hw/rtl/nmea_gga_field_parser.sv @@
// NMEA GGA field parser: top level with the full per-byte datapath.
// Depends on ngfp_pkg.
`timescale 1ns / 1ps

// Usage
//   s_tvalid/s_tready/s_tdata carry one received ASCII byte per request.
//   m_tvalid/m_tready/m_tdata/m_tlast return one result per input byte:
//   the running XOR (or the checksum match flag once a sentence ends), the
//   last decoded timestamp in centiseconds and the last latched altitude.
//   m_tlast marks the byte that was the second checksum digit.
//   cfg_valid/cfg_ready/cfg_index/cfg_data set the comma counts of the
//   timestamp, fix and altitude fields; write them only while idle.
// Timing
//   A byte's result is registered and shows in the cycle after it is taken.
//   Throughput is one byte per cycle while no stalled result blocks the input,
//   set by the single registered pass through the field logic to the result.
// Reset
//   rst_n clears all sentence state, the stored timestamp and altitude, and
//   restores the default field indexes; no result is pending after reset.
// Stalls
//   While m_tready is low the result holds; a new byte is still taken when
//   the result register is empty or is being emptied in the same cycle.
module nmea_gga_field_parser #(
    parameter int TIME_DIGITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input bytes: [7:0] rx_byte
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ngfp_pkg::BYTE_W-1:0]     s_tdata,
    // Results: [7:0] check_value, [33:8] time_centisec, [65:34] altitude,
    // [71:66] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ngfp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ngfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ngfp_pkg::FIELD_W-1:0]    cfg_data
);
    import ngfp_pkg::*;

    localparam int IDX_W = $clog2(TIME_DIGITS + 1);
    localparam logic [IDX_W-1:0] DIGIT_LIMIT = IDX_W'(TIME_DIGITS);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SUM  = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    // State registers
    phase_t               phase_reg,     phase_next;
    logic [BYTE_W-1:0]    xor_reg,       xor_next;
    logic [3:0]           chk_high_reg,  chk_high_next;
    logic [FIELD_W-1:0]   field_cnt_reg, field_cnt_next;
    logic [IDX_W-1:0]     digit_idx_reg, digit_idx_next;
    logic [TIME_W-1:0]    time_acc_reg,  time_acc_next;
    logic                 fix_valid_reg, fix_valid_next;
    logic                 alt_neg_reg,   alt_neg_next;
    logic                 alt_frac_reg,  alt_frac_next;
    logic [MAG_W-1:0]     alt_mag_reg,   alt_mag_next;
    logic [TIME_W-1:0]    time_out_reg,  time_out_next;
    logic [ALT_W-1:0]     alt_out_reg,   alt_out_next;
    logic                 done_next;

    // Field index registers
    logic [FIELD_W-1:0]   time_field_reg;
    logic [FIELD_W-1:0]   fix_field_reg;
    logic [FIELD_W-1:0]   alt_field_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic [BYTE_W-1:0]    out_check_reg;
    logic [TIME_W-1:0]    out_time_reg;
    logic [ALT_W-1:0]     out_alt_reg;

    logic                 in_fire;
    logic [3:0]           digit;
    logic [3:0]           rx_hex;
    logic [TIME_W-1:0]    digit_term;
    logic [MAG_W+3:0]     alt_prod;
    logic [ALT_W-1:0]     alt_signed;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - TIME_W - ALT_W){1'b0}},
                       out_alt_reg, out_time_reg, out_check_reg};

    // Decode the byte once for every consumer
    always_comb
    begin
        digit  = 4'(s_tdata - CH_ZERO);
        rx_hex = hex_value(s_tdata);
    end

    // Checksum tracking, then field handling on the post-checksum state
    always_comb
    begin
        phase_next     = phase_reg;
        xor_next       = xor_reg;
        chk_high_next  = chk_high_reg;
        field_cnt_next = field_cnt_reg;
        digit_idx_next = digit_idx_reg;
        time_acc_next  = time_acc_reg;
        fix_valid_next = fix_valid_reg;
        alt_neg_next   = alt_neg_reg;
        alt_frac_next  = alt_frac_reg;
        alt_mag_next   = alt_mag_reg;
        time_out_next  = time_out_reg;
        alt_out_next   = alt_out_reg;
        done_next      = 1'b0;
        digit_term     = '0;
        alt_prod       = '0;
        alt_signed     = '0;

        // Second checksum digit: compare, end the sentence, clear its state
        if (phase_reg == PH_LOW)
        begin
            xor_next       = ({chk_high_reg, rx_hex} == xor_reg) ? 8'd1 : 8'd0;
            done_next      = 1'b1;
            phase_next     = PH_IDLE;
            field_cnt_next = '0;
            digit_idx_next = '0;
            alt_neg_next   = 1'b0;
            alt_frac_next  = 1'b0;
            alt_mag_next   = '0;
        end
        // First checksum digit
        if (phase_reg == PH_HIGH)
        begin
            chk_high_next = rx_hex;
            phase_next    = PH_LOW;
        end
        if (s_tdata == CH_STAR)
            phase_next = PH_HIGH;
        if (phase_next == PH_SUM)
            xor_next = xor_next ^ s_tdata;
        if (s_tdata == CH_DOLLAR)
        begin
            phase_next = PH_SUM;
            xor_next   = '0;
        end

        // Field roles, first match wins
        if (s_tdata == CH_COMMA)
        begin
            if (field_cnt_next != FIELD_MAX)
                field_cnt_next = field_cnt_next + 4'd1;
        end
        else if (field_cnt_next == time_field_reg)
        begin
            // Accumulate weighted digits; the first digit restarts the sum
            if (s_tdata != CH_DOT && digit_idx_next < DIGIT_LIMIT)
            begin
                digit_term    = TIME_W'(time_weight(digit_idx_next[2:0])) * TIME_W'(digit);
                time_acc_next = (digit_idx_next == '0) ? digit_term
                                                       : time_acc_reg + digit_term;
                digit_idx_next = digit_idx_next + IDX_W'(1);
            end
            if (digit_idx_next == DIGIT_LIMIT)
                time_out_next = time_acc_next;
        end
        else if (field_cnt_next == fix_field_reg)
        begin
            fix_valid_next = (s_tdata > CH_ZERO);
        end
        else if (field_cnt_next == alt_field_reg)
        begin
            if (s_tdata == CH_MINUS)
                alt_neg_next = 1'b1;
            else if (s_tdata == CH_DOT)
                alt_frac_next = 1'b1;
            else if (!alt_frac_next)
            begin
                // magnitude * 10 + digit, saturated
                alt_prod = ({4'b0, alt_mag_next} << 3) + ({4'b0, alt_mag_next} << 1)
                           + (MAG_W+4)'(digit);
                alt_mag_next = (alt_prod > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX
                                                               : alt_prod[MAG_W-1:0];
            end
        end
        else if ({1'b0, field_cnt_next} == {1'b0, alt_field_reg} + 5'd1)
        begin
            // Latch the altitude in the field after it
            alt_signed   = alt_neg_next ? (ALT_W'(0) - {1'b0, alt_mag_next})
                                        : {1'b0, alt_mag_next};
            alt_out_next = fix_valid_reg ? alt_signed : NO_FIX_ALT;
        end
    end

    // Hold state, configuration and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            xor_reg        <= '0;
            chk_high_reg   <= '0;
            field_cnt_reg  <= '0;
            digit_idx_reg  <= '0;
            time_acc_reg   <= '0;
            fix_valid_reg  <= 1'b0;
            alt_neg_reg    <= 1'b0;
            alt_frac_reg   <= 1'b0;
            alt_mag_reg    <= '0;
            time_out_reg   <= '0;
            alt_out_reg    <= '0;
            time_field_reg <= TIME_FIELD_RST;
            fix_field_reg  <= FIX_FIELD_RST;
            alt_field_reg  <= ALT_FIELD_RST;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_check_reg  <= '0;
            out_time_reg   <= '0;
            out_alt_reg    <= '0;
        end
        else
        begin
            // Take a configuration request
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TIME_FIELD: time_field_reg <= cfg_data;
                    REG_FIX_FIELD:  fix_field_reg  <= cfg_data;
                    REG_ALT_FIELD:  alt_field_reg  <= cfg_data;
                    default:        ;
                endcase
            end

            // Advance on an accepted byte and load its result
            if (in_fire)
            begin
                phase_reg     <= phase_next;
                xor_reg       <= xor_next;
                chk_high_reg  <= chk_high_next;
                field_cnt_reg <= field_cnt_next;
                digit_idx_reg <= digit_idx_next;
                time_acc_reg  <= time_acc_next;
                fix_valid_reg <= fix_valid_next;
                alt_neg_reg   <= alt_neg_next;
                alt_frac_reg  <= alt_frac_next;
                alt_mag_reg   <= alt_mag_next;
                time_out_reg  <= time_out_next;
                alt_out_reg   <= alt_out_next;
                out_valid_reg <= 1'b1;
                out_last_reg  <= done_next;
                out_check_reg <= xor_next;
                out_time_reg  <= time_out_next;
                out_alt_reg   <= alt_out_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/ngfp_checker.sv @@
// Port-level checker for the NMEA GGA field parser, bound to the top level.
// Depends on ngfp_pkg and nmea_gga_field_parser_assert.svh.
`timescale 1ns / 1ps
`include "nmea_gga_field_parser_assert.svh"

module ngfp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ngfp_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ngfp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tlast
);
    import ngfp_pkg::*;

    // Hold a stalled result
    `NGFP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Every accepted byte leaves a result pending
    `NGFP_ASSERT_NEXT(a_byte_gives_result, s_tvalid && s_tready, m_tvalid, "accepted byte gave no result")

    // A finished sentence reports only match or mismatch
    `NGFP_ASSERT_NOW(a_done_flag, m_tvalid && m_tlast, m_tdata[BYTE_W-1:1] == '0, "checksum flag not 0 or 1")

    // Padding above the altitude stays zero
    `NGFP_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:BYTE_W+TIME_W+ALT_W] == '0, "tdata padding not zero")

endmodule

bind nmea_gga_field_parser ngfp_checker u_ngfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ test/tb_nmea_gga_field_parser.sv @@
// Testbench for nmea_gga_field_parser: streams GGA sentences and noise bytes,
// predicts every result in-line and compares it field by field.
// Depends on ngfp_pkg and the nmea_gga_field_parser top level.
`timescale 1ns / 1ps

module tb_nmea_gga_field_parser;
    import ngfp_pkg::*;

    // Checksum tracking phases of the parser
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SUM   = 2'd1;
    localparam logic [1:0] PH_CK_HI = 2'd2;
    localparam logic [1:0] PH_CK_LO = 2'd3;

    localparam int NDIG = 8;
    localparam int unsigned CS_WEIGHT [NDIG] =
        '{3600000, 360000, 60000, 6000, 1000, 100, 10, 1};

    typedef struct packed {
        logic        done;
        logic [7:0]  check;
        logic [25:0] tcs;
        logic [31:0] alt;
    } gga_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_TIME_FIELD;
    logic [FIELD_W-1:0]     cfg_data = '0;

    nmea_gga_field_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be sent and parse results waiting to come back
    logic [7:0]  byte_backlog [$];
    gga_result_t results_due [$];

    bit steady = 1'b0;
    int queued_total = 0;
    int bytes_taken = 0;
    int sentences_sent = 0;
    int results_seen = 0;
    int sentence_ends = 0;
    int checksum_hits = 0;
    int settings_run = 0;
    int mismatches = 0;

    // Shadow copy of the parser: field indexes and sentence state
    logic [3:0]  idx_time = TIME_FIELD_RST;
    logic [3:0]  idx_fix  = FIX_FIELD_RST;
    logic [3:0]  idx_alt  = ALT_FIELD_RST;
    logic [1:0]  ph = PH_IDLE;
    logic [7:0]  xor_acc = '0;
    logic [3:0]  ck_high = '0;
    logic [3:0]  commas = '0;
    logic [3:0]  ndig = '0;
    logic [3:0]  tdig [NDIG] = '{default: '0};
    logic        have_fix = 1'b0;
    logic        alt_neg = 1'b0;
    logic        alt_frac = 1'b0;
    logic [30:0] alt_mag = '0;
    logic [25:0] time_hold = '0;
    logic [31:0] alt_hold = '0;

    // Read a checksum character as hex, other characters wrap around '0'
    function automatic logic [3:0] ck_nibble(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CH_UP_A && c <= CH_UP_F)
                v = c - CH_UP_A + 8'd10;
            else if (c >= CH_LO_A && c <= CH_LO_F)
                v = c - CH_LO_A + 8'd10;
            else
                v = c - CH_ZERO;
            return v[3:0];
        end
    endfunction

    // Advance the shadow parser by one byte and queue the result it gives
    function void parse_byte(input logic [7:0] b);
        logic [7:0]  dv;
        logic [3:0]  d;
        logic [7:0]  rx;
        logic [63:0] m;
        logic [31:0] acc;
        gga_result_t r;
        begin
            dv = b - CH_ZERO;
            d = dv[3:0];
            r.done = 1'b0;
            // Second checksum digit closes the sentence
            if (ph == PH_CK_LO) begin
                rx = {ck_high, ck_nibble(b)};
                xor_acc = (rx == xor_acc) ? 8'd1 : 8'd0;
                r.done = 1'b1;
                alt_mag = '0;
                alt_frac = 1'b0;
                alt_neg = 1'b0;
                ndig = '0;
                commas = '0;
                ph = PH_IDLE;
            end
            if (ph == PH_CK_HI) begin
                ck_high = ck_nibble(b);
                ph = PH_CK_LO;
            end
            if (b == CH_STAR)
                ph = PH_CK_HI;
            if (ph == PH_SUM)
                xor_acc ^= b;
            if (b == CH_DOLLAR) begin
                ph = PH_SUM;
                xor_acc = '0;
            end
            // Field handling under the comma count as it stands now
            if (b == CH_COMMA) begin
                if (commas != FIELD_MAX)
                    commas++;
            end else if (commas == idx_time) begin
                if (b != CH_DOT && ndig < NDIG) begin
                    tdig[ndig[2:0]] = d;
                    ndig++;
                end
                if (ndig == NDIG) begin
                    acc = '0;
                    for (int k = 0; k < NDIG; k++)
                        acc += CS_WEIGHT[k] * tdig[k];
                    time_hold = acc[25:0];
                end
            end else if (commas == idx_fix) begin
                have_fix = (b > CH_ZERO);
            end else if (commas == idx_alt) begin
                if (b == CH_MINUS)
                    alt_neg = 1'b1;
                else if (b == CH_DOT)
                    alt_frac = 1'b1;
                else if (!alt_frac) begin
                    m = 64'(alt_mag) * 64'd10 + 64'(d);
                    if (m > 64'(MAG_MAX))
                        m = 64'(MAG_MAX);
                    alt_mag = m[30:0];
                end
            end else if ({1'b0, commas} == {1'b0, idx_alt} + 5'd1) begin
                if (have_fix)
                    alt_hold = alt_neg ? 32'd0 - {1'b0, alt_mag} : {1'b0, alt_mag};
                else
                    alt_hold = NO_FIX_ALT;
            end
            r.check = xor_acc;
            r.tcs = time_hold;
            r.alt = alt_hold;
            results_due.push_back(r);
        end
    endfunction

    function void flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h (result %0d)",
                     what, want, got, results_seen);
    endfunction

    function void enq(input logic [7:0] b);
        byte_backlog.push_back(b);
        queued_total++;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return (lower ? CH_LO_A : CH_UP_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] filler_char();
        return 8'($urandom_range(8'h2E, 8'h7E));
    endfunction

    // Build one sentence laid out for the current field indexes
    function automatic void add_sentence();
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] c0;
        logic [7:0] c1;
        int last_field;
        int n;
        int style;
        bit lower;
        begin
            last_field = int'(idx_alt) + 1;
            if (int'(idx_time) > last_field)
                last_field = int'(idx_time);
            if (int'(idx_fix) > last_field)
                last_field = int'(idx_fix);
            last_field += $urandom_range(0, 2);
            for (int k = 0; k <= last_field; k++) begin
                if (k > 0)
                    body.push_back(CH_COMMA);
                if (k == int'(idx_time) || (k > 15 && idx_time == FIELD_MAX)) begin
                    style = $urandom_range(0, 99);
                    if (style < 70) begin
                        n = $urandom_range(0, 23);
                        body.push_back(CH_ZERO + 8'(n / 10));
                        body.push_back(CH_ZERO + 8'(n % 10));
                        repeat (2) begin
                            n = $urandom_range(0, 59);
                            body.push_back(CH_ZERO + 8'(n / 10));
                            body.push_back(CH_ZERO + 8'(n % 10));
                        end
                        body.push_back(CH_DOT);
                        repeat (2) body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end else if (style < 85) begin
                        // Too many digits: only the leading ones count
                        repeat ($urandom_range(9, 12))
                            body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        body.push_back(CH_DOT);
                        body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end else begin
                        repeat ($urandom_range(1, 7))
                            body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end else if (k == int'(idx_fix) || (k > 15 && idx_fix == FIELD_MAX)) begin
                    if ($urandom_range(0, 9) < 3)
                        body.push_back(CH_ZERO);
                    else if ($urandom_range(0, 9) < 8)
                        body.push_back(CH_ZERO + 8'($urandom_range(1, 8)));
                    else
                        body.push_back(filler_char());
                end else if (k == int'(idx_alt) || (k > 15 && idx_alt == FIELD_MAX)) begin
                    if ($urandom_range(0, 1))
                        body.push_back(CH_MINUS);
                    n = ($urandom_range(0, 99) < 15) ? $urandom_range(10, 12)
                                                     : $urandom_range(1, 5);
                    repeat (n) body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    if ($urandom_range(0, 9) < 6) begin
                        body.push_back(CH_DOT);
                        repeat ($urandom_range(1, 2))
                            body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end else if (k == int'(idx_alt) + 1) begin
                    // Units field; must be non-empty so the altitude latches
                    repeat ($urandom_range(1, 2)) body.push_back(filler_char());
                end else if (k == 0 && $urandom_range(0, 9) < 8) begin
                    body.push_back(8'h47);
                    body.push_back(8'h50);
                    body.push_back(8'h47);
                    body.push_back(8'h47);
                    body.push_back(8'h41);
                end else begin
                    repeat ($urandom_range(0, 3)) body.push_back(filler_char());
                end
            end
            sum = '0;
            foreach (body[i])
                sum ^= body[i];
            // Corrupt the checksum now and then
            if ($urandom_range(0, 9) == 0)
                sum ^= 8'(1 << $urandom_range(0, 7));
            lower = $urandom_range(0, 1);
            c0 = hex_char(sum[7:4], lower);
            c1 = hex_char(sum[3:0], lower);
            if ($urandom_range(0, 29) == 0)
                c1 = filler_char();
            enq(CH_DOLLAR);
            foreach (body[i])
                enq(body[i]);
            enq(CH_STAR);
            enq(c0);
            enq(c1);
            sentences_sent++;
        end
    endfunction

    // Queue mostly sentences with some stray bytes in between
    function void fill_random(input int n);
        int goal;
        begin
            goal = queued_total + n;
            while (queued_total < goal) begin
                if ($urandom_range(0, 99) < 85)
                    add_sentence();
                else
                    repeat ($urandom_range(1, 4)) enq(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // Send one register write and track it in the shadow copy
    task automatic cfg_put(input cfg_reg_t r, input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        case (r)
            REG_TIME_FIELD: idx_time = v;
            REG_FIX_FIELD:  idx_fix = v;
            REG_ALT_FIELD:  idx_alt = v;
            default: ;
        endcase
    endtask

    task automatic set_fields(input logic [3:0] t, input logic [3:0] f,
                              input logic [3:0] a);
        cfg_put(REG_TIME_FIELD, t);
        cfg_put(REG_FIX_FIELD, f);
        cfg_put(REG_ALT_FIELD, a);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Wait until every queued byte is taken and every result is back
    task automatic wait_quiet();
        int guard;
        guard = 0;
        // Counters only lag within an edge, so a stale read only delays the exit
        do
        begin
            @(posedge clk);
            guard++;
        end
        while ((bytes_taken != queued_total || results_due.size() != 0) && guard < 20000);
        repeat (2) @(posedge clk);
    endtask

    // Byte driver: take the request, then offer the next byte or idle
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= byte_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each result against the oldest prediction
    always @(posedge clk)
    begin : result_check
        gga_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    flag_mismatch("unexpected result", '0, 64'(m_tdata[7:0]));
                end else begin
                    want = results_due.pop_front();
                    if (m_tlast !== want.done)
                        flag_mismatch("sentence end", 64'(want.done), 64'(m_tlast));
                    if (m_tdata[7:0] !== want.check)
                        flag_mismatch("check value", 64'(want.check), 64'(m_tdata[7:0]));
                    if (m_tdata[33:8] !== want.tcs)
                        flag_mismatch("time", 64'(want.tcs), 64'(m_tdata[33:8]));
                    if (m_tdata[65:34] !== want.alt)
                        flag_mismatch("altitude", 64'(want.alt), 64'(m_tdata[65:34]));
                    if (m_tdata[71:66] !== 6'd0)
                        flag_mismatch("padding", '0, 64'(m_tdata[71:66]));
                    if (want.done) begin
                        sentence_ends++;
                        if (want.check == 8'd1)
                            checksum_hits++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    // Main sequence: reset, directed bytes, then one random phase per setting
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset indexes: short sentences covering hex cases and raw extremes
        settings_run = 1;
        enq(CH_DOLLAR); enq(8'h41); enq(CH_STAR); enq(8'h34); enq(8'h31);
        enq(CH_DOLLAR); enq(8'h4A); enq(CH_STAR); enq(8'h34); enq(8'h41);
        enq(CH_DOLLAR); enq(8'h6A); enq(CH_STAR); enq(8'h36); enq(8'h61);
        enq(CH_DOLLAR); enq(8'h41); enq(CH_STAR); enq(8'h34); enq(8'h47);
        enq(CH_DOLLAR); enq(CH_STAR); enq(8'h30); enq(8'h30);
        enq(8'h00); enq(8'hFF);
        fill_random(75);
        wait_quiet();

        // Standard layout, with no idling on either side
        steady = 1'b1;
        cfg_put(REG_UNUSED, 4'($urandom_range(0, 15)));
        set_fields(4'd1, 4'd6, 4'd9);
        fill_random(75);
        wait_quiet();
        steady = 1'b0;

        // All roles on one field: the timestamp wins
        set_fields(4'd0, 4'd0, 4'd0);
        fill_random(75);
        wait_quiet();

        // Top indexes: saturated comma count, the timestamp wins, no altitude latched
        set_fields(FIELD_MAX, FIELD_MAX, FIELD_MAX);
        fill_random(75);
        wait_quiet();

        // Timestamp and fix share a field, altitude at the highest index that latches
        set_fields(4'd3, 4'd3, 4'd14);
        fill_random(75);
        wait_quiet();

        // Fix and altitude share a field
        set_fields(4'd5, 4'd8, 4'd8);
        fill_random(75);
        wait_quiet();

        set_fields(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)));
        fill_random(75);
        wait_quiet();

        if (results_due.size() != 0) begin
            mismatches += results_due.size();
            $display("%0d predicted results never arrived", results_due.size());
        end
        $display("Sent %0d bytes in %0d sentences over %0d index settings.",
                 bytes_taken, sentences_sent, settings_run);
        $display("Checked %0d results: %0d sentence ends, %0d checksum matches, %0d errors.",
                 results_seen, sentence_ends, checksum_hits, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Timed out with %0d results outstanding", results_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
